FILE: src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the qrs peak classifier
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_NOISE  = 3'd1;
  localparam logic [2:0] EV_REG    = 3'd2;
  localparam logic [2:0] EV_SEARCH = 3'd3;
  localparam logic [2:0] EV_MISSED = 3'd4;

  localparam logic CFG_SIGNAL = 1'b0;
  localparam logic CFG_NOISE  = 1'b1;

  localparam logic [15:0] RR_RESET   = 16'd150;
  localparam logic [15:0] LOW_INIT   = 16'd138;
  localparam logic [15:0] HIGH_INIT  = 16'd174;
  localparam logic [15:0] MISS_INIT  = 16'd249;
  localparam logic [15:0] LOW_PEAK   = 16'd2000;
  localparam logic [15:0] SIG_INIT   = 16'd2000;
  localparam logic [15:0] NOISE_INIT = 16'd500;
  localparam logic [8:0]  COEF_LOW   = 9'd236;
  localparam logic [8:0]  COEF_HIGH  = 9'd297;
  localparam logic [8:0]  COEF_MISS  = 9'd425;

  // request passed from front to back: one candidate peak or a plain sample
  typedef struct packed {
    logic        is_peak;
    logic [15:0] value;
    logic [31:0] time_stamp;
  } peak_req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] peak_time;
    logic [15:0] peak_value;
    logic [15:0] rr_interval;
    logic [13:0] pulse_bpm;
    logic        low_peak_warning;
    logic        missed_warning;
    logic [15:0] threshold_one_now;
  } qrs_res_t;

  function automatic logic [23:0] mix_level(input logic [23:0] lvl, input logic [15:0] v);
    logic [27:0] s;
    s = {4'd0, v, 8'd0} + 28'(lvl) * 28'd7;
    return s[26:3];
  endfunction

  function automatic logic [23:0] thr_one(input logic [23:0] noise, input logic [23:0] sig);
    logic [25:0] s;
    s = 26'(noise) * 26'd3 + 26'(sig);
    return s[25:2];
  endfunction

endpackage

FILE: src/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// sample window and local maximum detection
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [15:0] in_sample,
  output logic        in_full,
  output logic        req_valid,
  output peak_req_t   req,
  input  logic        req_full
);
  logic [15:0] middle_r, oldest_r;
  logic [31:0] clock_r;

  assign in_full   = req_full;
  assign req_valid = in_push && !req_full;
  assign req.is_peak    = (in_sample < middle_r) && (middle_r > oldest_r);
  assign req.value      = middle_r;
  assign req.time_stamp = clock_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      middle_r <= '0;
      oldest_r <= '0;
      clock_r  <= '0;
    end else if (req_valid) begin
      oldest_r <= middle_r;
      middle_r <= in_sample;
      clock_r  <= clock_r + 32'd1;
    end
  end
endmodule

FILE: src/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo
// small request queue between front and back
// ----------------------------------------------------------------------------
module qrs_fifo import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  peak_req_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output logic      empty,
  output peak_req_t rd_data
);
  peak_req_t   mem_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  assign full    = cnt_r == 3'd4;
  assign empty   = cnt_r == 3'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end
endmodule

FILE: src/qrs_divider.sv
// ----------------------------------------------------------------------------
// qrs_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qrs_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [39:0] divisor,
  output logic        busy,
  output logic [39:0] quotient
);
  logic [39:0] q_r, rem_r, d_r;
  logic [5:0]  n_r;
  logic [40:0] trial;

  assign busy     = n_r != 6'd0;
  assign quotient = q_r;
  assign trial    = {rem_r, q_r[39]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (start) begin
      n_r   <= 6'd40;
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy) begin
      n_r <= n_r - 6'd1;
      if (!trial[40]) begin
        rem_r <= trial[39:0];
        q_r   <= {q_r[38:0], 1'b1};
      end else begin
        rem_r <= {rem_r[38:0], q_r[39]};
        q_r   <= {q_r[38:0], 1'b0};
      end
    end
  end
endmodule

FILE: src/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// classification sequencer with peak history, rr stores and levels
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; #(
  parameter int PEAK_HISTORY = 128,
  parameter int RR_WINDOW    = 8,
  parameter int SAMPLE_RATE  = 250
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_empty,
  input  peak_req_t   req,
  output logic        req_pop,
  input  logic        cfg_we,
  input  logic        cfg_sel,
  input  logic [15:0] cfg_val,
  output logic        cfg_ready,
  output logic        res_valid,
  output qrs_res_t    res,
  input  logic        res_ready
);
  localparam int HW = (PEAK_HISTORY > 1) ? $clog2(PEAK_HISTORY) : 1;
  localparam int CW = $clog2(PEAK_HISTORY + 1);
  localparam int RW = (RR_WINDOW > 1) ? $clog2(RR_WINDOW) : 1;
  localparam int KW = $clog2(RR_WINDOW + 1);
  localparam logic [39:0] BPM_K = 40'(60 * SAMPLE_RATE);
  localparam logic [HW-1:0] LAST = HW'(PEAK_HISTORY - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_SB_RD, S_SB_CHK, S_LIM_SUM, S_LIM_DIV, S_PULSE_SUM,
    S_PULSE_DIV, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] val_mem [PEAK_HISTORY];
  logic [31:0] time_mem [PEAK_HISTORY];
  logic [15:0] rd_val_r;
  logic [31:0] rd_time_r;
  logic [HW-1:0] rd_idx, wr_idx_r, sb_lo;
  logic        wr_en_r;

  logic [15:0] rr_reg_r [RR_WINDOW];
  logic [15:0] rr_any_r [RR_WINDOW];

  logic [HW-1:0] head_r;
  logic [CW-1:0] fill_r, since_r, sb_i_r;
  logic [23:0] sig_r, noise_r, thr1_r;
  logic [15:0] low_r, high_r, miss_r;
  logic [31:0] last_r;
  logic [2:0]  mrun_r;
  logic        use_any_r;
  logic [RW:0] it_r;
  logic        stop_r;
  logic [19:0] sum_r;
  logic [KW-1:0] cnt_r;
  logic [1:0]  lim_r;
  qrs_res_t    out_r, idle_res;
  peak_req_t   cur_r;

  logic        div_start, div_busy;
  logic        div_done, busy_d_r;
  logic [39:0] div_num, div_den, div_q;
  logic [31:0] rr_diff;
  logic [15:0] rr_sat, cur_rr;
  logic [8:0]  coef;
  logic [23:0] thr2, noise_mix, thr_mix;
  logic [15:0] st_e;

  qrs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_den), .busy(div_busy), .quotient(div_q)
  );

  assign thr2      = thr1_r >> 1;
  assign res_valid = state_r == S_OUT;
  assign res       = out_r;
  assign req_pop   = state_r == S_IDLE && !req_empty;
  assign cfg_ready = state_r == S_IDLE && req_empty;
  assign sb_lo     = sb_i_r[HW-1:0];
  assign rd_idx    = (sb_lo <= head_r) ? head_r - sb_lo
                   : HW'(PEAK_HISTORY + int'(head_r) - int'(sb_lo));
  assign coef    = (lim_r == 2'd0) ? COEF_LOW : (lim_r == 2'd1) ? COEF_HIGH : COEF_MISS;
  assign st_e    = use_any_r ? rr_any_r[it_r[RW-1:0]] : rr_reg_r[it_r[RW-1:0]];
  assign noise_mix = mix_level(noise_r, cur_r.value);
  assign thr_mix   = thr_one(noise_mix, sig_r);

  always_comb begin
    idle_res = '0;
    idle_res.threshold_one_now = thr1_r[23:8];
  end

  always_comb begin
    rr_diff = cur_r.time_stamp - last_r;
    if (state_r == S_SB_CHK) rr_diff = rd_time_r - last_r;
    rr_sat = (rr_diff > 32'd65535) ? 16'hffff : rr_diff[15:0];
  end
  assign cur_rr = rr_sat;

  // a division starts once the divider is idle and its last result was taken
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 40'd1;
    if (state_r == S_LIM_DIV && !div_busy && !busy_d_r && !stop_r) begin
      div_start = 1'b1;
      div_num   = 40'(sum_r) * 40'(coef);
      div_den   = {22'd0, 10'(cnt_r), 8'd0};
    end else if (state_r == S_PULSE_DIV && !div_busy && !busy_d_r && !stop_r) begin
      div_start = 1'b1;
      div_num   = 40'(cnt_r) * BPM_K;
      div_den   = 40'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      val_mem[wr_idx_r]  <= cur_r.value;
      time_mem[wr_idx_r] <= cur_r.time_stamp;
    end
    rd_val_r  <= val_mem[rd_idx];
    rd_time_r <= time_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; fill_r <= '0; since_r <= '0;
      sig_r <= {SIG_INIT, 8'd0};
      noise_r <= {NOISE_INIT, 8'd0};
      thr1_r <= thr_one({NOISE_INIT, 8'd0}, {SIG_INIT, 8'd0});
      low_r <= LOW_INIT; high_r <= HIGH_INIT; miss_r <= MISS_INIT;
      last_r <= '0; mrun_r <= '0; wr_en_r <= 1'b0;
      for (int i = 0; i < RR_WINDOW; i++) begin
        rr_reg_r[i] <= RR_RESET;
        rr_any_r[i] <= RR_RESET;
      end
    end else begin
      wr_en_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_sel == CFG_SIGNAL) begin
          sig_r  <= {cfg_val, 8'd0};
          thr1_r <= thr_one(noise_r, {cfg_val, 8'd0});
        end else begin
          noise_r <= {cfg_val, 8'd0};
          thr1_r  <= thr_one({cfg_val, 8'd0}, sig_r);
        end
      end
      case (state_r)
        S_IDLE: begin
          if (!req_empty) begin
            cur_r <= req;
            out_r <= idle_res;
            if (req.is_peak) begin
              head_r  <= (head_r == LAST) ? '0 : head_r + HW'(1);
              wr_idx_r <= (head_r == LAST) ? '0 : head_r + HW'(1);
              wr_en_r <= 1'b1;
              if (fill_r != CW'(PEAK_HISTORY)) fill_r <= fill_r + CW'(1);
              if (since_r != CW'(PEAK_HISTORY)) since_r <= since_r + CW'(1);
              state_r <= S_CLASS;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_CLASS: begin
          out_r.peak_time  <= cur_r.time_stamp;
          out_r.peak_value <= cur_r.value;
          if ({cur_r.value, 8'd0} <= thr1_r) begin
            out_r.event_res <= EV_NOISE;
            noise_r <= noise_mix;
            thr1_r  <= thr_mix;
            out_r.threshold_one_now <= thr_mix[23:8];
            state_r <= S_OUT;
          end else begin
            out_r.rr_interval <= cur_rr;
            if (cur_rr > low_r && cur_rr < high_r) begin
              out_r.event_res <= EV_REG;
              mrun_r <= '0;
              sig_r <= mix_level(sig_r, cur_r.value);
              for (int i = RR_WINDOW - 1; i > 0; i--) begin
                rr_reg_r[i] <= rr_reg_r[i-1];
                rr_any_r[i] <= rr_any_r[i-1];
              end
              rr_reg_r[0] <= cur_rr;
              rr_any_r[0] <= cur_rr;
              last_r  <= cur_r.time_stamp;
              since_r <= '0;
              out_r.low_peak_warning <= cur_r.value < LOW_PEAK;
              use_any_r <= 1'b0;
              it_r <= '0; sum_r <= '0; cnt_r <= '0; stop_r <= 1'b0;
              state_r <= S_LIM_SUM;
            end else begin
              out_r.event_res <= EV_MISSED;
              if (mrun_r != 3'd7) mrun_r <= mrun_r + 3'd1;
              out_r.missed_warning <= (mrun_r + 3'd1 > 3'd4) || mrun_r == 3'd7;
              sb_i_r <= CW'(1);
              state_r <= (cur_rr > miss_r) ? S_SB_RD : S_OUT;
            end
          end
        end
        S_SB_RD: begin
          if (sb_i_r < since_r && sb_i_r < fill_r) state_r <= S_SB_CHK;
          else state_r <= S_OUT;
        end
        S_SB_CHK: begin
          if ({rd_val_r, 8'd0} > thr2) begin
            out_r.event_res   <= EV_SEARCH;
            out_r.peak_time   <= rd_time_r;
            out_r.peak_value  <= rd_val_r;
            out_r.rr_interval <= cur_rr;
            for (int i = RR_WINDOW - 1; i > 0; i--) rr_any_r[i] <= rr_any_r[i-1];
            rr_any_r[0] <= cur_rr;
            last_r  <= rd_time_r;
            since_r <= sb_i_r;
            sig_r   <= mix_level(sig_r, rd_val_r);
            out_r.low_peak_warning <= rd_val_r < LOW_PEAK;
            use_any_r <= 1'b1;
            it_r <= '0; sum_r <= '0; cnt_r <= '0; stop_r <= 1'b0;
            state_r <= S_LIM_SUM;
          end else begin
            sb_i_r  <= sb_i_r + CW'(1);
            state_r <= S_SB_RD;
          end
        end
        S_LIM_SUM: begin
          if (it_r == (RW+1)'(RR_WINDOW) || st_e == 16'd0) begin
            stop_r <= cnt_r == '0;
            lim_r  <= 2'd0;
            thr1_r <= thr_one(noise_r, sig_r);
            state_r <= S_LIM_DIV;
          end else begin
            sum_r <= sum_r + 20'(st_e);
            cnt_r <= cnt_r + KW'(1);
            it_r  <= it_r + (RW+1)'(1);
          end
        end
        S_LIM_DIV: begin
          out_r.threshold_one_now <= thr1_r[23:8];
          if (stop_r) begin
            it_r <= '0; sum_r <= '0; cnt_r <= '0; stop_r <= 1'b0;
            state_r <= S_PULSE_SUM;
          end else if (div_done) begin
            case (lim_r)
              2'd0: low_r  <= (div_q > 40'd65535) ? 16'hffff : div_q[15:0];
              2'd1: high_r <= (div_q > 40'd65535) ? 16'hffff : div_q[15:0];
              default: miss_r <= (div_q > 40'd65535) ? 16'hffff : div_q[15:0];
            endcase
            if (lim_r == 2'd2) begin
              it_r <= '0; sum_r <= '0; cnt_r <= '0; stop_r <= 1'b0;
              state_r <= S_PULSE_SUM;
            end else begin
              lim_r <= lim_r + 2'd1;
            end
          end
        end
        S_PULSE_SUM: begin
          if (it_r == (RW+1)'(RR_WINDOW)) begin
            stop_r <= sum_r == '0;
            state_r <= S_PULSE_DIV;
          end else begin
            if (rr_any_r[it_r[RW-1:0]] != 16'd0) begin
              sum_r <= sum_r + 20'(rr_any_r[it_r[RW-1:0]]);
              cnt_r <= cnt_r + KW'(1);
            end
            it_r <= it_r + (RW+1)'(1);
          end
        end
        S_PULSE_DIV: begin
          if (stop_r) begin
            out_r.pulse_bpm <= '0;
            state_r <= S_OUT;
          end else if (div_done) begin
            out_r.pulse_bpm <= (div_q > 40'd16383) ? 14'h3fff : div_q[13:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // flag the cycle after the divider drops busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_d_r <= 1'b0;
    end else begin
      busy_d_r <= div_busy;
    end
  end
  assign div_done = busy_d_r && !div_busy;

endmodule

FILE: src/qrs_peak_classifier.sv
// ----------------------------------------------------------------------------
// qrs_peak_classifier
// peak decision stage of a qrs detector
// ----------------------------------------------------------------------------
// one sample in, one result out. the front keeps the sample window, spots
// local maxima in the cycle a sample is accepted and queues a request in a
// four-deep queue; the back sequencer passes a sample that is no peak
// straight to its output state and takes a noise peak through the class
// state, then waits for the result to be popped. an r peak goes through the
// class state, rr summing, three divisions for the rr limits, pulse summing,
// one pulse division and the output state. searchback examines stored
// peaks one at a time (one memory read each). configuration writes are taken
// only while the back end is idle and the queue is empty, and reload a level
// and threshold one.
module qrs_peak_classifier import qrs_pkg::*; #(
  parameter int PEAK_HISTORY = 128,
  parameter int RR_WINDOW    = 8,
  parameter int SAMPLE_RATE  = 250
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_sample,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_res,
  output logic [31:0] out_peak_time,
  output logic [15:0] out_peak_value,
  output logic [15:0] out_rr_interval,
  output logic [13:0] out_pulse_bpm,
  output logic        out_low_peak_warning,
  output logic        out_missed_warning,
  output logic [15:0] out_threshold_one_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  peak_req_t f_req, b_req;
  logic      f_valid, q_full, q_empty, q_pop, res_valid;
  qrs_res_t  res;

  // request front
  qrs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_sample(in_sample),
    .in_full(in_full), .req_valid(f_valid), .req(f_req), .req_full(q_full)
  );

  // decoupling queue
  qrs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_req), .full(q_full),
    .rd_en(q_pop), .empty(q_empty), .rd_data(b_req)
  );

  // classification back end, result held in its output register
  qrs_back #(
    .PEAK_HISTORY(PEAK_HISTORY), .RR_WINDOW(RR_WINDOW), .SAMPLE_RATE(SAMPLE_RATE)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .req_empty(q_empty), .req(b_req), .req_pop(q_pop),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index[0]), .cfg_val(cfg_data),
    .cfg_ready(cfg_ready), .res_valid(res_valid), .res(res), .res_ready(out_pop)
  );

  assign out_empty = !res_valid;
  assign out_event_res         = res.event_res;
  assign out_peak_time         = res.peak_time;
  assign out_peak_value        = res.peak_value;
  assign out_rr_interval       = res.rr_interval;
  assign out_pulse_bpm         = res.pulse_bpm;
  assign out_low_peak_warning  = res.low_peak_warning;
  assign out_missed_warning    = res.missed_warning;
  assign out_threshold_one_now = res.threshold_one_now;
endmodule

FILE: src/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// port level checks of the qrs peak classifier
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_event_res,
  input logic [31:0] out_peak_time,
  input logic [15:0] out_rr_interval
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == 1'b0 && !out_pop |=> out_empty == 1'b0 && $stable(out_event_res))
    else $error("result changed while stalled");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_event_res == EV_NONE |-> out_peak_time == 32'd0)
    else $error("no event with peak time");
  a_noise: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_event_res == EV_NOISE |-> out_rr_interval == 16'd0)
    else $error("noise peak with rr");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_event_res <= EV_MISSED)
    else $error("bad event code");
endmodule

bind qrs_peak_classifier qrs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_event_res(out_event_res), .out_peak_time(out_peak_time),
  .out_rr_interval(out_rr_interval)
);
